// File: rtl/core/rgbbc_pkg.sv
// Shared types and constants for the gray/brightness/contrast pipeline.
package rgbbc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAYIFY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_PICK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_INDEX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd5;

	localparam logic [1:0] KIND_BITMAP = 2'd0;
	localparam logic [1:0] KIND_GRAY   = 2'd1;
	localparam logic [1:0] KIND_COLOR  = 2'd2;

	// 100 percent in 16.16
	localparam logic signed [24:0] CONTRAST_UNIT = 25'sd6553600;

	// floor(x/3) = (x*683) >> 11 for x < 2048
	localparam logic [9:0] RECIP3 = 10'd683;
	localparam int RECIP3_SHIFT = 11;

	// floor(x/100) = (x*167773) >> 24 for x < 199728
	localparam logic [17:0] RECIP100 = 18'd167773;
	localparam int RECIP100_SHIFT = 24;

	localparam logic signed [11:0] MID_LEVEL = 12'sd128;
	localparam logic signed [11:0] MAX_LEVEL = 12'sd255;

	typedef struct packed {
		logic [1:0]         image_kind;
		logic               grayify;
		logic               chan_pick;
		logic [1:0]         pass_index;
		logic signed [23:0] brightness;
		logic signed [23:0] contrast;
	} cfg_t;

endpackage

// File: rtl/core/rgbbc_cfg.sv
// Configuration register file.
module rgbbc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rgbbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbbc_pkg::CFG_DATA_W-1:0] cfg_data,
	output rgbbc_pkg::cfg_t                  cfg
);
	import rgbbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_kind <= KIND_COLOR;
			cfg_q.grayify    <= 1'b0;
			cfg_q.chan_pick  <= 1'b0;
			cfg_q.pass_index <= 2'd0;
			cfg_q.brightness <= '0;
			cfg_q.contrast   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_KIND: cfg_q.image_kind <= cfg_data[1:0];
				REG_GRAYIFY:    cfg_q.grayify    <= cfg_data[0];
				REG_CHAN_PICK:  cfg_q.chan_pick  <= cfg_data[0];
				REG_PASS_INDEX: cfg_q.pass_index <= cfg_data[1:0];
				REG_BRIGHTNESS: cfg_q.brightness <= cfg_data;
				REG_CONTRAST:   cfg_q.contrast   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/rgbbc_group.sv
// Stage 1: triple grouping (gray average or channel pick) and input register.
module rgbbc_group (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbbc_pkg::cfg_t cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            frame_start,
	input  logic            nxt_ready,
	output logic            valid_s1,
	output logic [8:0]      val_s1
);
	import rgbbc_pkg::*;

	logic [1:0]  phase_q;
	logic [9:0]  psum_q;
	logic [1:0]  phase;
	logic [9:0]  psum;
	logic [10:0] sum;
	logic [20:0] q3_prod;
	logic [1:0]  chan;
	logic        grouping;
	logic        emit;
	logic        accept;
	logic [8:0]  val;
	logic [1:0]  phase_nxt;
	logic [9:0]  psum_nxt;

	assign in_ready = !valid_s1 || nxt_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		case (cfg.pass_index)
			2'd0:    chan = 2'd1;
			2'd1:    chan = 2'd2;
			2'd2:    chan = 2'd0;
			default: chan = 2'd1;
		endcase
	end

	always_comb begin
		phase = frame_start ? 2'd0 : phase_q;
		psum = frame_start ? 10'd0 : psum_q;
		sum = {1'b0, psum} + {3'd0, data_byte};
		q3_prod = 21'(sum) * 21'(RECIP3);
		grouping = (cfg.image_kind == KIND_COLOR) && (cfg.grayify || cfg.chan_pick);
		emit = 1'b1;
		val = {1'b0, data_byte};
		phase_nxt = phase;
		psum_nxt = psum;
		if (grouping) begin
			phase_nxt = (phase >= 2'd2) ? 2'd0 : phase + 2'd1;
			if (cfg.grayify) begin
				if (phase >= 2'd2) begin
					val = q3_prod[RECIP3_SHIFT+8:RECIP3_SHIFT];
					psum_nxt = 10'd0;
				end else begin
					emit = 1'b0;
					psum_nxt = sum[9:0];
				end
			end else begin
				emit = (phase == chan);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			psum_q <= 10'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_nxt;
				psum_q <= psum_nxt;
			end
			if (in_ready)
				valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit)
			val_s1 <= val;
	end

endmodule

// File: rtl/core/rgbbc_scale.sv
// Stage 2: sign/magnitude product of (byte-128) and contrast gain.
module rgbbc_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbbc_pkg::cfg_t cfg,
	input  logic            valid_s1,
	input  logic [8:0]      val_s1,
	output logic            ready_s1,
	input  logic            nxt_ready,
	output logic            valid_s2,
	output logic [32:0]     mag_s2,
	output logic            neg_s2,
	output logic [7:0]      byte_s2
);
	import rgbbc_pkg::*;

	logic signed [9:0]  diff;
	logic signed [24:0] gain;
	logic [8:0]         diff_mag;
	logic [23:0]        gain_mag;
	logic [9:0]         diff_neg;
	logic [24:0]        gain_neg;

	assign ready_s1 = !valid_s2 || nxt_ready;

	always_comb begin
		diff = signed'({1'b0, val_s1}) - 10'sd128;
		gain = 25'(cfg.contrast) + CONTRAST_UNIT;
		diff_neg = -diff;
		gain_neg = -gain;
		diff_mag = diff[9] ? diff_neg[8:0] : diff[8:0];
		gain_mag = gain[24] ? gain_neg[23:0] : gain[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (ready_s1)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			mag_s2 <= 33'(diff_mag) * 33'(gain_mag);
			neg_s2 <= diff[9] ^ gain[24];
			byte_s2 <= val_s1[7:0];
		end
	end

endmodule

// File: rtl/core/rgbbc_out.sv
// Stage 3: divide by 100%, add brightness, clamp, output register; bitmaps pass through.
module rgbbc_out (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbbc_pkg::cfg_t cfg,
	input  logic            valid_s2,
	input  logic [32:0]     mag_s2,
	input  logic            neg_s2,
	input  logic [7:0]      byte_s2,
	output logic            ready_s2,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte
);
	import rgbbc_pkg::*;

	logic [16:0]        x;
	logic [34:0]        q_prod;
	logic [10:0]        q;
	logic signed [11:0] sq;
	logic signed [11:0] bright;
	logic signed [11:0] v;
	logic [7:0]         adj;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;

	assign ready_s2 = !out_valid_q || out_ready;

	always_comb begin
		x = mag_s2[32:16];
		q_prod = 35'(x) * 35'(RECIP100);
		q = q_prod[RECIP100_SHIFT+10:RECIP100_SHIFT];
		sq = neg_s2 ? -signed'({1'b0, q}) : signed'({1'b0, q});
		bright = 12'($signed(cfg.brightness[23:16]));
		v = sq + bright + MID_LEVEL;
		if (v < 12'sd0)
			adj = 8'd0;
		else if (v > MAX_LEVEL)
			adj = 8'hFF;
		else
			adj = v[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ready_s2)
			out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2)
			out_byte_q <= (cfg.image_kind == KIND_BITMAP) ? byte_s2 : adj;
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;

endmodule

// File: rtl/core/rgb_gray_brightness_contrast_top.sv
// A beat is registered in every stage; bytes dropped by grouping give no beat.
// Throughput: one beat per cycle through three registered stages (group, multiply,
// divide/clamp); in_ready falls only when all stages hold data and out_ready is low.
// Reset: pipeline empties, grouping phase and partial sum clear, image_kind resets to
// color, all other config registers to zero.
module rgb_gray_brightness_contrast_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rgbbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             frame_start,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte
);
	import rgbbc_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [8:0]  val_s1;
	logic        ready_s1;
	logic        valid_s2;
	logic [32:0] mag_s2;
	logic        neg_s2;
	logic [7:0]  byte_s2;
	logic        ready_s2;

	rgbbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rgbbc_group u_group (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.nxt_ready   (ready_s1),
		.valid_s1    (valid_s1),
		.val_s1      (val_s1)
	);

	rgbbc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.val_s1    (val_s1),
		.ready_s1  (ready_s1),
		.nxt_ready (ready_s2),
		.valid_s2  (valid_s2),
		.mag_s2    (mag_s2),
		.neg_s2    (neg_s2),
		.byte_s2   (byte_s2)
	);

	rgbbc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.mag_s2    (mag_s2),
		.neg_s2    (neg_s2),
		.byte_s2   (byte_s2),
		.ready_s2  (ready_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte)
	);

endmodule

// File: rtl/core/rgbbc_chk.sv
// Port-level checker for the top level, attached by bind.
module rgbbc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       frame_start,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte
);

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(frame_start))
		else $error("input beat changed while stalled");

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output beat changed while stalled");

	// input backpressure only when the output is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// a fresh output beat comes from an earlier accepted input beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(in_valid && in_ready, 3))
		else $error("output beat without matching input beat");

	// nothing leaves right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind rgb_gray_brightness_contrast_top rgbbc_chk u_chk (.*);
